/* rtl/core/fbba_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the free block bitmap allocator.
// No dependencies; imported by free_block_bitmap_allocator_unit.

package fbba_pkg;

  // request and result field widths
  localparam int unsigned IDX_W = 14;
  localparam int unsigned KIND_W = 2;

  // summary memory: one bit per map word, fixed width so grouping is a shift
  localparam int unsigned SUM_BITS = 32;
  localparam int unsigned SUM_SHIFT = 5;

  // parameter defaults
  localparam int unsigned MAP_WORDS_DEF = 512;
  localparam int unsigned WORD_BITS_DEF = 32;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_FIND      = 2'd0,
    KIND_MARK_USED = 2'd1,
    KIND_MARK_FREE = 2'd2
  } kind_t;

  // request payload
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  block_index;
  } request_t;

  // result payload
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] result_index;
  } result_t;

endpackage

/* rtl/core/free_block_bitmap_allocator_unit.sv */
`timescale 1ns / 1ps
// Free block bitmap allocator: map memory, word summary memory and control.
// Depends on fbba_pkg for payload types, request kinds and constants.

// The block keeps one bit per storage block (1 = free) in a map memory of
// MAP_WORDS words of WORD_BITS bits, plus a summary memory holding one bit
// per map word that is set while that word still has a free block, and a
// small register vector marking non-empty summary entries. After reset busy
// stays high for a clearing pass that sets every block free. A request is
// taken when start is high and busy is low; its result is shown on result
// for exactly one cycle with done high and must be captured then, as the
// block cannot be held off. A find checks the top vector one chunk at a time,
// each chunk standing for a 1024-word stretch of map, then reads the summary
// word and then the map word, each read being registered. A find that meets
// no free block answers with found low once the last chunk is checked. A mark
// splits the block number into word and bit by reciprocal division (S_M_DIV
// then S_M_REM), then reads and writes back both memories (S_M_READ then
// S_M_MOD), or answers from S_M_READ with no write when the word lies beyond
// the map. A request of an unused kind answers in the next cycle. A new
// request is accepted in the cycle its predecessor's result is shown.

module free_block_bitmap_allocator_unit
  import fbba_pkg::*;
#(
  parameter int unsigned MAP_WORDS = MAP_WORDS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  // derived sizes
  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BW = $clog2(WORD_BITS);
  localparam int unsigned QW = IDX_W - BW + 1;
  localparam int unsigned SUM_WORDS = (MAP_WORDS + SUM_BITS - 1) / SUM_BITS;
  localparam int unsigned SAW = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
  localparam int unsigned TOP_CHUNKS = (SUM_WORDS + SUM_BITS - 1) / SUM_BITS;
  localparam int unsigned TCW = (TOP_CHUNKS > 1) ? $clog2(TOP_CHUNKS) : 1;
  localparam int unsigned BLK_W = AW + BW;
  localparam int unsigned DIV_SHIFT = 21;
  localparam int unsigned PW = IDX_W + DIV_SHIFT + 1;
  localparam logic [DIV_SHIFT:0] RECIP = (DIV_SHIFT + 1)'((2 ** DIV_SHIFT) / WORD_BITS);

  typedef logic [TOP_CHUNKS-1:0][SUM_BITS-1:0] top_vec_t;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_F_TOP  = 9'b000000100,
    S_F_SUM  = 9'b000001000,
    S_F_MAP  = 9'b000010000,
    S_M_DIV  = 9'b000100000,
    S_M_REM  = 9'b001000000,
    S_M_READ = 9'b010000000,
    S_M_MOD  = 9'b100000000
  } state_t;

  // lowest set bit of a map word
  function automatic logic [BW-1:0] low_word(input logic [WORD_BITS-1:0] v);
    logic [BW-1:0] p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) p = BW'(i);
    end
    return p;
  endfunction

  // lowest set bit of a summary word
  function automatic logic [SUM_SHIFT-1:0] low_sum(input logic [SUM_BITS-1:0] v);
    logic [SUM_SHIFT-1:0] p;
    p = '0;
    for (int i = SUM_BITS - 1; i >= 0; i--) begin
      if (v[i]) p = SUM_SHIFT'(i);
    end
    return p;
  endfunction

  // summary entry after reset: bits only for map words that exist
  function automatic logic [SUM_BITS-1:0] sum_init(input logic [SAW-1:0] g);
    logic [SUM_BITS-1:0] v;
    for (int j = 0; j < SUM_BITS; j++) begin
      v[j] = ((int'(g) * SUM_BITS + j) < MAP_WORDS);
    end
    return v;
  endfunction

  // top vector after reset: bits only for summary entries that exist
  function automatic top_vec_t top_init();
    top_vec_t v;
    for (int c = 0; c < TOP_CHUNKS; c++) begin
      for (int j = 0; j < SUM_BITS; j++) begin
        v[c][j] = ((c * SUM_BITS + j) < SUM_WORDS);
      end
    end
    return v;
  endfunction

  // memories
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [SUM_BITS-1:0]  sum_mem [SUM_WORDS];

  logic                 map_we;
  logic [AW-1:0]        map_wa;
  logic [WORD_BITS-1:0] map_wd;
  logic [AW-1:0]        map_ra;
  logic [WORD_BITS-1:0] map_rd;
  logic                 sum_we;
  logic [SAW-1:0]       sum_wa;
  logic [SUM_BITS-1:0]  sum_wd;
  logic [SAW-1:0]       sum_ra;
  logic [SUM_BITS-1:0]  sum_rd;

  // registers
  state_t              state;
  logic [AW-1:0]       clr_addr;
  top_vec_t            top_bits;
  logic [TCW-1:0]      chunk;
  logic [SAW-1:0]      group_q;
  logic [AW-1:0]       fword_q;
  logic [IDX_W-1:0]    idx_q;
  logic [KIND_W-1:0]   kind_q;
  logic [QW-1:0]       q_est;
  logic [QW-1:0]       word_q;
  logic [BW-1:0]       bit_q;

  // combinational datapath
  logic [SUM_BITS-1:0]  chunk_bits;
  logic [SAW-1:0]       top_group;
  logic [AW-1:0]        sum_word;
  logic [BLK_W-1:0]     blk;
  logic [PW-1:0]        prod;
  logic [IDX_W:0]       rem_full;
  logic [AW-1:0]        word_addr;
  logic [SAW-1:0]       wgroup;
  logic [SUM_SHIFT-1:0] wsbit;
  logic [WORD_BITS-1:0] sel;
  logic [WORD_BITS-1:0] new_word;
  logic [SUM_BITS-1:0]  new_sum;

  assign busy = (state != S_IDLE);

  // find path: top chunk, summary word, map word
  assign chunk_bits = top_bits[chunk];
  assign top_group  = SAW'({chunk, low_sum(chunk_bits)});
  assign sum_word   = AW'({group_q, low_sum(sum_rd)});
  assign blk        = BLK_W'(fword_q) * BLK_W'(WORD_BITS) + BLK_W'(low_word(map_rd));

  // block number split by reciprocal multiply with one correction
  assign prod     = PW'(idx_q) * PW'(RECIP);
  assign rem_full = (IDX_W + 1)'(idx_q) - (IDX_W + 1)'(q_est) * (IDX_W + 1)'(WORD_BITS);

  // mark path: read-modify-write of map word and its summary bit
  assign word_addr = AW'(word_q);
  assign wgroup    = SAW'(word_addr >> SUM_SHIFT);
  assign wsbit     = SUM_SHIFT'(word_addr);
  assign sel       = WORD_BITS'(1) << bit_q;
  assign new_word  = (kind_q == KIND_MARK_USED) ? (map_rd & ~sel) : (map_rd | sel);
  always_comb begin
    new_sum        = sum_rd;
    new_sum[wsbit] = |new_word;
  end

  // memory port control
  always_comb begin
    map_we = 1'b0;
    map_wa = clr_addr;
    map_wd = '1;
    map_ra = word_addr;
    sum_we = 1'b0;
    sum_wa = SAW'(clr_addr >> SUM_SHIFT);
    sum_wd = sum_init(SAW'(clr_addr >> SUM_SHIFT));
    sum_ra = wgroup;
    unique case (state)
      S_CLEAR: begin
        map_we = 1'b1;
        sum_we = 1'b1;
      end
      S_F_TOP: begin
        sum_ra = top_group;
      end
      S_F_SUM: begin
        map_ra = sum_word;
      end
      S_M_MOD: begin
        map_we = 1'b1;
        map_wa = word_addr;
        map_wd = new_word;
        sum_we = 1'b1;
        sum_wa = wgroup;
        sum_wd = new_sum;
      end
      default: begin
      end
    endcase
  end

  // map memory
  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_rd <= map_mem[map_ra];
  end

  // summary memory
  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    sum_rd <= sum_mem[sum_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      top_bits <= top_init();
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(MAP_WORDS - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            idx_q  <= request.block_index;
            kind_q <= request.kind;
            case (request.kind)
              KIND_FIND: begin
                chunk <= '0;
                state <= S_F_TOP;
              end
              KIND_MARK_USED, KIND_MARK_FREE: begin
                state <= S_M_DIV;
              end
              default: begin
                done                <= 1'b1;
                result.found        <= 1'b0;
                result.result_index <= '0;
              end
            endcase
          end
        end
        S_F_TOP: begin
          if (|chunk_bits) begin
            group_q <= top_group;
            state   <= S_F_SUM;
          end else if (chunk == TCW'(TOP_CHUNKS - 1)) begin
            done                <= 1'b1;
            result.found        <= 1'b0;
            result.result_index <= '0;
            state               <= S_IDLE;
          end else begin
            chunk <= chunk + TCW'(1);
          end
        end
        S_F_SUM: begin
          fword_q <= sum_word;
          state   <= S_F_MAP;
        end
        S_F_MAP: begin
          done                <= 1'b1;
          result.found        <= 1'b1;
          result.result_index <= IDX_W'(blk);
          state               <= S_IDLE;
        end
        S_M_DIV: begin
          q_est <= QW'(prod >> DIV_SHIFT);
          state <= S_M_REM;
        end
        S_M_REM: begin
          if (rem_full >= (IDX_W + 1)'(WORD_BITS)) begin
            word_q <= q_est + QW'(1);
            bit_q  <= BW'(rem_full - (IDX_W + 1)'(WORD_BITS));
          end else begin
            word_q <= q_est;
            bit_q  <= BW'(rem_full);
          end
          state <= S_M_READ;
        end
        S_M_READ: begin
          if (32'(word_q) >= 32'(MAP_WORDS)) begin
            done                <= 1'b1;
            result.found        <= 1'b1;
            result.result_index <= idx_q;
            state               <= S_IDLE;
          end else begin
            state <= S_M_MOD;
          end
        end
        S_M_MOD: begin
          top_bits[TCW'(wgroup >> SUM_SHIFT)][SUM_SHIFT'(wgroup)] <= |new_sum;
          done                <= 1'b1;
          result.found        <= 1'b1;
          result.result_index <= idx_q;
          state               <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
